// ===== sv/ssm_pkg.sv =====
package ssm_pkg;

    localparam int DATA_W = 32;
    // holds a full row of rounded 32x32 products plus the offset without wrapping
    localparam int ACC_W  = 56;

    typedef enum logic [1:0] {
        CMD_INIT   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_LOAD   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_STATE_DIM  = 2'd0;
    localparam logic [1:0] REG_INPUT_DIM  = 2'd1;
    localparam logic [1:0] REG_OUTPUT_DIM = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [6:0]         coef_addr;
        logic signed [31:0] coef_value;
        logic signed [31:0] in_0;
        logic signed [31:0] in_1;
        logic signed [31:0] in_2;
        logic signed [31:0] in_3;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_0;
        logic signed [31:0] out_1;
        logic signed [31:0] out_2;
        logic signed [31:0] out_3;
        logic               saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_U_RD,
        ST_U_CALC,
        ST_ROW_RD,
        ST_ROW_OFS,
        ST_TERM_RD,
        ST_TERM_MUL,
        ST_TERM_ACC,
        ST_ROW_END,
        ST_COMMIT,
        ST_OUT
    } state_t;

    // Saturate an exact sum to 32 bits.
    function automatic logic [32:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [32:0] r;
        if (v > ACC_W'(64'sd2147483647))
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -ACC_W'(64'sd2147483648))
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

// ===== sv/ssm_ram.sv =====
module ssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ssm_mac.sv =====
// Shared multiply-accumulate: Q16.16 product rounded, added into a wide accumulator.
module ssm_mac
    import ssm_pkg::*;
(
    input  logic                     clk,
    input  logic                     mul_en,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    input  logic                     acc_load,
    input  logic signed [DATA_W-1:0] acc_init,
    input  logic                     acc_add,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [63:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [63:0]      rnd;

    assign rnd = prod_reg + 64'sd32768;

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= a * b;
        if (acc_load)
            acc_reg <= ACC_W'(acc_init);
        else if (acc_add)
            acc_reg <= acc_reg + ACC_W'(rnd >>> 16);
    end

    assign acc = acc_reg;

endmodule

// ===== sv/state_space_model_step.sv =====
// Discrete state-space model, Q16.16. Load writes one coefficient word, init copies
// x_init into the state (a table read and a write per state), sample computes
// u' = u - u0, x' = A x + B u' + xoff, y = C x + D u' + y0 on one shared multiplier
// and accumulator. Each input offset is a table read then a subtract, each term a table
// read, multiply and accumulate, each active row adds an offset read, an accumulator
// load and a row end, and each inactive row is only its offset read.
// The table read port serializes everything; stall is high while an item is in work
// or its result waits. Coefficient memory is cleared by a pass over all 80 words
// after reset; items are not taken meanwhile.
module state_space_model_step
    import ssm_pkg::*;
#(
    parameter int MAX_STATES  = 4,
    parameter int MAX_INPUTS  = 4,
    parameter int MAX_OUTPUTS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item
);

    localparam int OFS_B  = MAX_STATES * MAX_STATES;
    localparam int OFS_C  = OFS_B + MAX_STATES * MAX_INPUTS;
    localparam int OFS_D  = OFS_C + MAX_OUTPUTS * MAX_STATES;
    localparam int OFS_U0 = OFS_D + MAX_OUTPUTS * MAX_INPUTS;
    localparam int OFS_Y0 = OFS_U0 + MAX_INPUTS;
    localparam int OFS_XO = OFS_Y0 + MAX_OUTPUTS;
    localparam int OFS_XI = OFS_XO + MAX_STATES;
    localparam int DEPTH  = OFS_XI + MAX_STATES;
    localparam int AW     = $clog2(DEPTH);
    localparam int MAXD   = (MAX_STATES > MAX_INPUTS) ? MAX_STATES : MAX_INPUTS;
    localparam int ROWS   = MAX_STATES + MAX_OUTPUTS;
    localparam int RW     = $clog2(ROWS + 1);
    localparam int CW     = $clog2(MAXD + 1);

    // config
    logic [2:0] sdim_reg, idim_reg, odim_reg;
    logic [3:0] ns, ni, no;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sdim_reg <= '0;
            idim_reg <= '0;
            odim_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STATE_DIM:  sdim_reg <= cfg_data;
                REG_INPUT_DIM:  idim_reg <= cfg_data;
                REG_OUTPUT_DIM: odim_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ns = ({1'b0, sdim_reg} > 4'(MAX_STATES))  ? 4'(MAX_STATES)  : {1'b0, sdim_reg};
    assign ni = ({1'b0, idim_reg} > 4'(MAX_INPUTS))  ? 4'(MAX_INPUTS)  : {1'b0, idim_reg};
    assign no = ({1'b0, odim_reg} > 4'(MAX_OUTPUTS)) ? 4'(MAX_OUTPUTS) : {1'b0, odim_reg};

    // sequencer
    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [AW:0] clr_reg;
    logic        clearing;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic          phase_reg;        // 0: state terms, 1: input terms
    logic          flag_reg;
    logic signed [DATA_W-1:0] x_reg  [MAX_STATES];
    logic signed [DATA_W-1:0] xn_reg [MAX_STATES];
    logic signed [DATA_W-1:0] u_reg  [MAX_INPUTS];
    logic signed [DATA_W-1:0] y_reg  [MAX_OUTPUTS];
    out_item_t out_reg;
    logic      out_valid_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    logic signed [ACC_W-1:0] acc;
    logic                    mul_en, acc_load, acc_add;
    logic signed [DATA_W-1:0] mul_b;

    logic is_out_row;
    logic [RW-1:0] orow;
    logic [3:0] ncols;
    logic last_row;
    logic signed [DATA_W:0] udiff;
    logic [32:0] usat, asat;
    logic signed [DATA_W-1:0] in_sel;

    assign clearing   = (clr_reg != (AW+1)'(DEPTH));
    assign is_out_row = row_reg >= RW'(MAX_STATES);
    assign orow       = row_reg - RW'(MAX_STATES);
    assign ncols      = phase_reg ? ni : ns;
    assign last_row   = row_reg == RW'(ROWS - 1);

    always_comb
    begin
        case (col_reg)
            CW'(0):  in_sel = item_reg.in_0;
            CW'(1):  in_sel = item_reg.in_1;
            CW'(2):  in_sel = item_reg.in_2;
            CW'(3):  in_sel = item_reg.in_3;
            default: in_sel = '0;
        endcase
    end

    assign udiff = {in_sel[DATA_W-1], in_sel} - {ram_rdata[DATA_W-1], ram_rdata};
    assign usat  = sat32(ACC_W'(udiff));
    assign asat  = sat32(acc);

    // row active test
    logic row_active;
    assign row_active = is_out_row ? ({1'b0, orow} < (RW+1)'(no))
                                   : ({1'b0, row_reg} < (RW+1)'(ns));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && !clearing)
                begin
                    unique case (cmd_t'(in_item.command))
                        CMD_INIT:   state_next = (ns != 0) ? ST_INIT_RD : ST_IDLE;
                        CMD_SAMPLE: state_next = (ni != 0) ? ST_U_RD : ST_ROW_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            ST_INIT_RD: state_next = ST_INIT_WR;
            ST_INIT_WR:
                state_next = ({1'b0, col_reg} + 1'b1 >= (CW+1)'(ns)) ? ST_IDLE : ST_INIT_RD;
            ST_U_RD:    state_next = ST_U_CALC;
            ST_U_CALC:
                state_next = ({1'b0, col_reg} + 1'b1 >= (CW+1)'(ni)) ? ST_ROW_RD : ST_U_RD;
            ST_ROW_RD:
                if (!row_active)
                    state_next = last_row ? ST_COMMIT : ST_ROW_RD;
                else
                    state_next = ST_ROW_OFS;
            ST_ROW_OFS:
                state_next = (ns != 0 || ni != 0) ? ST_TERM_RD : ST_ROW_END;
            ST_TERM_RD:
                state_next = ({1'b0, col_reg} >= (CW+1)'(ncols)) ? ST_TERM_RD : ST_TERM_MUL;
            ST_TERM_MUL: state_next = ST_TERM_ACC;
            ST_TERM_ACC:
                if ({1'b0, col_reg} + 1'b1 < (CW+1)'(ncols))
                    state_next = ST_TERM_RD;
                else if (!phase_reg && ni != 0)
                    state_next = ST_TERM_RD;
                else
                    state_next = ST_ROW_END;
            ST_ROW_END: state_next = last_row ? ST_COMMIT : ST_ROW_RD;
            ST_COMMIT:  state_next = ST_OUT;
            ST_OUT:     state_next = out_valid_reg ? ST_OUT : ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
        // skip empty phase
        if (state_reg == ST_TERM_RD && {1'b0, col_reg} >= (CW+1)'(ncols))
            state_next = ST_TERM_RD;
    end

    // table address
    always_comb
    begin
        ram_raddr = '0;
        unique case (state_reg)
            ST_INIT_RD: ram_raddr = AW'(OFS_XI + int'(col_reg));
            ST_U_RD:    ram_raddr = AW'(OFS_U0 + int'(col_reg));
            ST_ROW_RD:
                ram_raddr = is_out_row ? AW'(OFS_Y0 + int'(orow)) : AW'(OFS_XO + int'(row_reg));
            ST_TERM_RD:
                if (!is_out_row)
                    ram_raddr = phase_reg ? AW'(OFS_B + int'(row_reg) * MAX_INPUTS + int'(col_reg))
                                          : AW'(int'(row_reg) * MAX_STATES + int'(col_reg));
                else
                    ram_raddr = phase_reg ? AW'(OFS_D + int'(orow) * MAX_INPUTS + int'(col_reg))
                                          : AW'(OFS_C + int'(orow) * MAX_STATES + int'(col_reg));
            default: ram_raddr = '0;
        endcase
    end

    assign ram_we    = clearing || (state_reg == ST_IDLE && in_valid
                       && cmd_t'(in_item.command) == CMD_LOAD
                       && {1'b0, in_item.coef_addr} < 8'(DEPTH));
    assign ram_waddr = clearing ? clr_reg[AW-1:0] : in_item.coef_addr[AW-1:0];
    assign ram_wdata = clearing ? '0 : in_item.coef_value;

    ssm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mul_en   = state_reg == ST_TERM_MUL;
    assign acc_load = state_reg == ST_ROW_OFS;
    assign acc_add  = state_reg == ST_TERM_ACC;
    assign mul_b    = phase_reg ? u_reg[col_reg[$clog2(MAX_INPUTS > 1 ? MAX_INPUTS : 2)-1:0]]
                                : x_reg[col_reg[$clog2(MAX_STATES > 1 ? MAX_STATES : 2)-1:0]];

    // coefficient comes straight off the table read port in the multiply cycle
    ssm_mac u_mac (
        .clk      (clk),
        .mul_en   (mul_en),
        .a        (ram_rdata),
        .b        (mul_b),
        .acc_load (acc_load),
        .acc_init (ram_rdata),
        .acc_add  (acc_add),
        .acc      (acc)
    );

    assign in_stall  = clearing || state_reg != ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            phase_reg     <= 1'b0;
            flag_reg      <= 1'b0;
            for (int k = 0; k < MAX_STATES; k++)
                x_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    col_reg   <= '0;
                    row_reg   <= '0;
                    phase_reg <= 1'b0;
                    flag_reg  <= 1'b0;
                end
                ST_INIT_WR:
                begin
                    x_reg[col_reg[$clog2(MAX_STATES > 1 ? MAX_STATES : 2)-1:0]] <= ram_rdata;
                    col_reg <= col_reg + 1'b1;
                end
                ST_U_CALC:
                begin
                    u_reg[col_reg[$clog2(MAX_INPUTS > 1 ? MAX_INPUTS : 2)-1:0]] <= usat[31:0];
                    if (usat[32])
                        flag_reg <= 1'b1;
                    col_reg <= ({1'b0, col_reg} + 1'b1 >= (CW+1)'(ni)) ? '0 : col_reg + 1'b1;
                end
                ST_ROW_RD:
                begin
                    col_reg   <= '0;
                    phase_reg <= (ns == 0);
                    if (!row_active)
                    begin
                        if (is_out_row)
                            y_reg[orow[$clog2(MAX_OUTPUTS > 1 ? MAX_OUTPUTS : 2)-1:0]] <= '0;
                        if (!last_row)
                            row_reg <= row_reg + 1'b1;
                    end
                end
                ST_TERM_RD:
                    if ({1'b0, col_reg} >= (CW+1)'(ncols))
                    begin
                        phase_reg <= 1'b1;
                        col_reg   <= '0;
                    end
                ST_TERM_MUL:
                    ;
                ST_TERM_ACC:
                    if ({1'b0, col_reg} + 1'b1 < (CW+1)'(ncols))
                        col_reg <= col_reg + 1'b1;
                    else
                    begin
                        col_reg   <= '0;
                        phase_reg <= 1'b1;
                    end
                ST_ROW_END:
                begin
                    if (asat[32])
                        flag_reg <= 1'b1;
                    if (is_out_row)
                        y_reg[orow[$clog2(MAX_OUTPUTS > 1 ? MAX_OUTPUTS : 2)-1:0]]
                            <= asat[31:0];
                    else
                        xn_reg[row_reg[$clog2(MAX_STATES > 1 ? MAX_STATES : 2)-1:0]]
                            <= asat[31:0];
                    if (!last_row)
                        row_reg <= row_reg + 1'b1;
                end
                ST_COMMIT:
                begin
                    for (int k = 0; k < MAX_STATES; k++)
                        if (k < int'(ns))
                            x_reg[k] <= xn_reg[k];
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !clearing)
            item_reg <= in_item;
        if (state_reg == ST_COMMIT)
        begin
            out_reg.out_0     <= (MAX_OUTPUTS > 0) ? y_reg[0] : '0;
            out_reg.out_1     <= (MAX_OUTPUTS > 1) ? y_reg[1 % MAX_OUTPUTS] : '0;
            out_reg.out_2     <= (MAX_OUTPUTS > 2) ? y_reg[2 % MAX_OUTPUTS] : '0;
            out_reg.out_3     <= (MAX_OUTPUTS > 3) ? y_reg[3 % MAX_OUTPUTS] : '0;
            out_reg.saturated <= flag_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("item accepted while busy");
    a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_COMMIT))
        else $error("result without commit");
    a_no_items_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> in_stall)
        else $error("item taken during clear");
`endif

endmodule

// ===== bench/tb_state_space_model_step.sv =====
`timescale 1ns / 1ps

module tb_state_space_model_step;
    import ssm_pkg::*;

    localparam int NSTATE = 4;
    localparam int NIN = 4;
    localparam int NOUT = 4;
    localparam int OFS_B = 16;
    localparam int OFS_C = 32;
    localparam int OFS_D = 48;
    localparam int OFS_U0 = 64;
    localparam int OFS_Y0 = 68;
    localparam int OFS_XOFF = 72;
    localparam int OFS_XINIT = 76;
    localparam int TABLE_DEPTH = 80;
    localparam int IDLE_LIMIT = 20000;
    // a load or init causes no result; let it finish before touching registers
    localparam int SETTLE_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [2:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;

    state_space_model_step uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    // predictor state
    longint    coef_mem [TABLE_DEPTH];
    longint    x_vec [NSTATE];
    int        dim_state, dim_input, dim_output;

    in_item_t  pending_items [$];
    out_item_t expected_outputs [$];
    bit        failed;
    int        idle_cycles;

    always #5 clk = ~clk;

    function automatic longint clip32(longint v, ref bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Q16.16 multiply, round to nearest, ties up: arithmetic shift floors
    function automatic longint q_mult(longint a, longint b);
        longint p;
        p = a * b + 32768;
        return p >>> 16;
    endfunction

    // apply one accepted item to the model; push the expected output if any
    function automatic void predict_item(in_item_t it);
        int ns, ni, no;
        longint u [NIN];
        longint xn [NSTATE];
        longint y [NOUT];
        longint acc;
        logic signed [31:0] raw [NIN];
        bit flag;
        out_item_t r;
        ns = (dim_state > NSTATE) ? NSTATE : dim_state;
        ni = (dim_input > NIN) ? NIN : dim_input;
        no = (dim_output > NOUT) ? NOUT : dim_output;
        raw[0] = it.in_0; raw[1] = it.in_1; raw[2] = it.in_2; raw[3] = it.in_3;
        flag = 0;
        case (cmd_t'(it.command))
            CMD_LOAD:
            begin
                if (it.coef_addr < TABLE_DEPTH)
                    coef_mem[it.coef_addr] = longint'(it.coef_value);
            end
            CMD_INIT:
            begin
                for (int i = 0; i < ns; i++)
                    x_vec[i] = coef_mem[OFS_XINIT + i];
            end
            CMD_SAMPLE:
            begin
                for (int j = 0; j < ni; j++)
                    u[j] = clip32(longint'(raw[j]) - coef_mem[OFS_U0 + j], flag);
                for (int i = 0; i < ns; i++)
                begin
                    acc = coef_mem[OFS_XOFF + i];
                    for (int j = 0; j < ns; j++)
                        acc += q_mult(coef_mem[i * NSTATE + j], x_vec[j]);
                    for (int j = 0; j < ni; j++)
                        acc += q_mult(coef_mem[OFS_B + i * NIN + j], u[j]);
                    xn[i] = clip32(acc, flag);
                end
                for (int i = 0; i < NOUT; i++)
                begin
                    y[i] = 0;
                    if (i < no)
                    begin
                        acc = coef_mem[OFS_Y0 + i];
                        for (int j = 0; j < ns; j++)
                            acc += q_mult(coef_mem[OFS_C + i * NSTATE + j], x_vec[j]);
                        for (int j = 0; j < ni; j++)
                            acc += q_mult(coef_mem[OFS_D + i * NIN + j], u[j]);
                        y[i] = clip32(acc, flag);
                    end
                end
                for (int i = 0; i < ns; i++)
                    x_vec[i] = xn[i];
                r.out_0 = y[0][31:0];
                r.out_1 = y[1][31:0];
                r.out_2 = y[2][31:0];
                r.out_3 = y[3][31:0];
                r.saturated = flag;
                expected_outputs.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // Driver: bursts of random length with random gaps.
    int burst_left, gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_item(in_item);
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    in_item  <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern: alternating stretches of free flow and random stalls.
    int stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= (stall_phase + 1) % 4000;
            if (stall_phase < 1500)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 2) != 0);
        end
    end

    // Monitor and checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_outputs.size() == 0)
            begin
                $display("%0t: unexpected output, actual %h", $time, out_item);
                failed = 1;
            end
            else
            begin
                out_item_t e;
                e = expected_outputs.pop_front();
                if (out_item.out_0 !== e.out_0)
                begin
                    $display("%0t: out_0 expected %h actual %h", $time, e.out_0, out_item.out_0);
                    failed = 1;
                end
                if (out_item.out_1 !== e.out_1)
                begin
                    $display("%0t: out_1 expected %h actual %h", $time, e.out_1, out_item.out_1);
                    failed = 1;
                end
                if (out_item.out_2 !== e.out_2)
                begin
                    $display("%0t: out_2 expected %h actual %h", $time, e.out_2, out_item.out_2);
                    failed = 1;
                end
                if (out_item.out_3 !== e.out_3)
                begin
                    $display("%0t: out_3 expected %h actual %h", $time, e.out_3, out_item.out_3);
                    failed = 1;
                end
                if (out_item.saturated !== e.saturated)
                begin
                    $display("%0t: saturated expected %b actual %b", $time,
                             e.saturated, out_item.saturated);
                    failed = 1;
                end
            end
        end
    end

    // Watchdog: cycles with no accepted item on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 262143)) - 131072);
            default: return $urandom;
        endcase
    endfunction

    // modest Q16.16 coefficient so that most steps stay unsaturated
    function automatic logic [31:0] rand_coef();
        if ($urandom_range(0, 9) == 0)
            return rand_word();
        return 32'($signed($urandom_range(0, 98304)) - 49152);
    endfunction

    function automatic in_item_t make_item(cmd_t c, int addr, logic [31:0] v);
        in_item_t it;
        it.command = c;
        it.coef_addr = 7'(addr);
        it.coef_value = v;
        it.in_0 = rand_word();
        it.in_1 = rand_word();
        it.in_2 = rand_word();
        it.in_3 = rand_word();
        return it;
    endfunction

    function automatic in_item_t make_sample();
        in_item_t it;
        it = make_item(CMD_SAMPLE, $urandom_range(0, 127), $urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            it.in_0 = rand_coef() * 4;
            it.in_1 = rand_coef() * 4;
            it.in_2 = rand_coef() * 4;
            it.in_3 = rand_coef() * 4;
        end
        return it;
    endfunction

    task automatic write_reg(logic [1:0] idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 3'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        // predictor follows the register the same cycle it is written
        case (idx)
            REG_STATE_DIM:  dim_state  = value;
            REG_INPUT_DIM:  dim_input  = value;
            REG_OUTPUT_DIM: dim_output = value;
            default: ;
        endcase
    endtask

    // wait until the queue is drained and the block is idle again
    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_outputs.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int dims [3];
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_STATE_DIM;
        cfg_data = 0;
        failed = 0;
        idle_cycles = 0;
        dim_state = 0;
        dim_input = 0;
        dim_output = 0;
        foreach (coef_mem[k]) coef_mem[k] = 0;
        foreach (x_vec[k]) x_vec[k] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero dimensions give zero outputs, then full size.
        pending_items.push_back(make_item(CMD_SAMPLE, 0, 0));
        pending_items.push_back(make_item(CMD_NONE, 5, 32'h1234));
        pending_items.push_back(make_item(CMD_LOAD, 127, 32'hFFFF_FFFF));
        pending_items.push_back(make_item(CMD_LOAD, TABLE_DEPTH, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(CMD_LOAD, OFS_Y0, 32'h7FFF_FFFF));
        drain();
        write_reg(REG_STATE_DIM, 4);
        write_reg(REG_INPUT_DIM, 4);
        write_reg(REG_OUTPUT_DIM, 4);
        // identity A, large offsets to hit saturation, u0 extreme for input overflow
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(CMD_LOAD, i * 5, 32'h0001_0000));
        pending_items.push_back(make_item(CMD_LOAD, OFS_U0, 32'h8000_0000));
        pending_items.push_back(make_item(CMD_LOAD, OFS_XOFF, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(CMD_LOAD, OFS_XINIT + 3, 32'h8000_0000));
        pending_items.push_back(make_item(CMD_LOAD, OFS_C, 32'h7FFF_FFFF));
        pending_items.push_back(make_item(CMD_LOAD, OFS_D + 15, 32'h8000_0000));
        pending_items.push_back(make_item(CMD_LOAD, TABLE_DEPTH - 1, 32'h0002_8000));
        pending_items.push_back(make_item(CMD_INIT, 0, 0));
        for (int k = 0; k < 4; k++)
            pending_items.push_back(make_sample());
        drain();
        write_reg(REG_STATE_DIM, 7);
        write_reg(REG_INPUT_DIM, 5);
        write_reg(REG_OUTPUT_DIM, 6);
        pending_items.push_back(make_item(CMD_INIT, 0, 0));
        pending_items.push_back(make_sample());
        pending_items.push_back(make_sample());
        drain();

        // Random phases: reload the table, init, then mostly samples.
        for (int ph = 0; ph < 12; ph++)
        begin
            for (int r = 0; r < 3; r++)
                dims[r] = (ph < 2) ? ((ph == 0) ? 0 : 7) : $urandom_range(0, 7);
            write_reg(REG_STATE_DIM, dims[0]);
            write_reg(REG_INPUT_DIM, dims[1]);
            write_reg(REG_OUTPUT_DIM, dims[2]);
            for (int a = 0; a < TABLE_DEPTH; a++)
                if ($urandom_range(0, 2) == 0)
                    pending_items.push_back(make_item(CMD_LOAD, a, rand_coef()));
            pending_items.push_back(make_item(CMD_INIT, 0, 0));
            for (int k = 0; k < 128; k++)
            begin
                case ($urandom_range(0, 19))
                    0: pending_items.push_back(make_item(CMD_LOAD,
                           $urandom_range(0, 127), rand_word()));
                    1: pending_items.push_back(make_item(CMD_INIT, 0, 0));
                    2: pending_items.push_back(make_item(CMD_NONE,
                           $urandom_range(0, 127), $urandom));
                    default: pending_items.push_back(make_sample());
                endcase
            end
            // pause the sender until everything expected has arrived
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (!failed && expected_outputs.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
